@@ rtl/spfa_pkg.sv @@
`default_nettype none
package spfa_pkg;
  localparam int NodeW = 10;
  localparam int EdgeW = 12;
  localparam int LinkW = EdgeW + 1;
  localparam int MaxNodes = 1 << NodeW;
  localparam int MaxEdges = 1 << EdgeW;
  localparam int CountW = NodeW + 1;
  localparam logic [31:0] Unreached = 32'h3f3f3f3f;
  localparam logic [LinkW-1:0] NullLink = {LinkW{1'b1}};

  localparam logic [1:0] KindLoad = 2'd0;
  localparam logic [1:0] KindRun = 2'd1;
  localparam logic [1:0] KindRead = 2'd2;

  localparam logic [1:0] StatOk = 2'd0;
  localparam logic [1:0] StatCycle = 2'd1;
  localparam logic [1:0] StatOvf = 2'd2;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_LOAD, S_CLEAR, S_POP, S_HEAD, S_FETCH, S_EDGE, S_DIST,
    S_RELAX, S_IMPL, S_IDIST, S_DONE, S_READ
  } state_t;

  // Relax unit request/answer
  typedef struct packed {
    logic [31:0] src_dist;
    logic [15:0] weight;
    logic [31:0] dst_dist;
  } relax_req_t;

  typedef struct packed {
    logic        improve;
    logic [31:0] sum;
  } relax_rsp_t;
endpackage
`default_nettype wire

@@ rtl/spfa_relax.sv @@
`default_nettype none
module spfa_relax (
  input  wire spfa_pkg::relax_req_t req,
  output spfa_pkg::relax_rsp_t      rsp
);
  logic signed [33:0] sum;
  always_comb begin
    sum = {{2{req.src_dist[31]}}, req.src_dist} + {{18{req.weight[15]}}, req.weight};
    if (sum > 34'sh07fffffff) rsp.sum = 32'h7fffffff;
    else if (sum < -34'sh080000000) rsp.sum = 32'h80000000;
    else rsp.sum = sum[31:0];
    rsp.improve = $signed(req.dst_dist) > $signed(rsp.sum);
  end
endmodule
`default_nettype wire

@@ rtl/spfa_shortest_path_engine.sv @@
`default_nettype none
// SPFA shortest-path engine.
// Command channel: raise start with kind/from_node/to_node/weight/query_node;
// the transfer happens at the edge where busy is low. kind 0 stores an edge
// (newest first per node) and gives no result; kind 1 runs queue-based
// Bellman-Ford from node 0 and returns one status result; kind 2 returns the
// stored distance of query_node; kind 3 is dropped without a result.
// Results sit on the result ports for one cycle with done high; the receiver
// cannot stall, so nothing is ever held back.
// Load: busy in S_LOAD after the transfer (head read, then link write).
// Read: done rises from S_READ, which passes on the registered r_dist.
// Run: a sweep of all nodes clearing distances, queue marks and counts, then
// POP, HEAD, FETCH, EDGE per popped node, EDGE, DIST, RELAX, IMPL per stored
// edge, IDIST, RELAX, IMPL per implicit edge from node 0, then DONE (one port
// each for distance and edge store, one shared saturating add/compare).
// Reset: node_count goes to 1 and busy stays high during a sweep of all nodes
// that empties every adjacency list and sets all distances to 0x3f3f3f3f.
// Config: APB register node_count at address 0, pready always high.
module spfa_shortest_path_engine (
  input  wire         clk,
  input  wire         rst,
  input  wire         start,
  output logic        busy,
  input  wire  [1:0]  kind,
  input  wire  [9:0]  from_node,
  input  wire  [9:0]  to_node,
  input  wire  [15:0] weight,
  input  wire  [9:0]  query_node,
  output logic        done,
  output logic        is_distance,
  output logic [1:0]  status,
  output logic [31:0] distance,
  input  wire         psel,
  input  wire         penable,
  input  wire         pwrite,
  input  wire         paddr,
  input  wire  [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int NW = spfa_pkg::NodeW;
  localparam int EW = spfa_pkg::EdgeW;
  localparam int LW = spfa_pkg::LinkW;

  spfa_pkg::state_t state, state_next;
  logic [NW-1:0] node_count;

  logic [NW-1:0] e_tgt [spfa_pkg::MaxEdges];
  logic [15:0]   e_wt  [spfa_pkg::MaxEdges];
  logic [LW-1:0] e_lnk [spfa_pkg::MaxEdges];
  logic [LW-1:0] head  [spfa_pkg::MaxNodes];
  logic [31:0]   dist_mem [spfa_pkg::MaxNodes];
  logic          in_q  [spfa_pkg::MaxNodes];
  logic [spfa_pkg::CountW-1:0] cnt [spfa_pkg::MaxNodes];
  logic [NW-1:0] ring  [spfa_pkg::MaxNodes];

  logic [LW-1:0] edge_used;
  logic          ovf;
  logic [NW-1:0] rd_start, ring_fill_lo;
  logic [NW:0]   ring_fill;
  logic [NW-1:0] cur, dst, idx, ld_from;
  logic [LW-1:0] eptr;
  logic [15:0]   ew;
  logic [31:0]   cur_dist;
  logic          cycle;
  logic          ew_impl;

  // registered memory reads
  logic [NW-1:0] r_tgt; logic [15:0] r_wt; logic [LW-1:0] r_lnk;
  logic [LW-1:0] r_head;
  logic [31:0]   r_dist;
  logic [spfa_pkg::CountW-1:0] r_cnt;
  logic          r_inq;
  logic [NW-1:0] r_ring;

  spfa_pkg::relax_req_t req;
  spfa_pkg::relax_rsp_t rsp;
  spfa_relax u_relax (.req(req), .rsp(rsp));
  assign req.src_dist = cur_dist;
  assign req.weight = ew;
  assign req.dst_dist = r_dist;

  logic [NW-1:0] dist_ra, head_ra, ring_ra;
  logic [EW-1:0] edge_ra;
  logic [NW-1:0] top;
  logic          accept;
  assign accept = start && !busy;
  // node_count never exceeds MaxNodes-1, so it bounds the implicit edges as is
  assign top = node_count;
  assign busy = state != spfa_pkg::S_IDLE;
  assign pready = 1'b1;
  assign prdata = (paddr == 1'b0) ? {22'd0, node_count} : 32'd0;
  assign ring_fill_lo = rd_start + ring_fill[NW-1:0];

  always_comb begin
    dist_ra = dst;
    head_ra = cur;
    ring_ra = rd_start;
    edge_ra = eptr[EW-1:0];
    state_next = state;
    case (state)
      spfa_pkg::S_INIT: if (idx == NW'(spfa_pkg::MaxNodes - 1)) state_next = spfa_pkg::S_IDLE;
      spfa_pkg::S_IDLE: begin
        dist_ra = query_node;
        head_ra = from_node;
        if (accept) begin
          case (kind)
            spfa_pkg::KindLoad: state_next = edge_used[EW] ? spfa_pkg::S_IDLE
                                                           : spfa_pkg::S_LOAD;
            spfa_pkg::KindRun: state_next = spfa_pkg::S_CLEAR;
            spfa_pkg::KindRead: state_next = spfa_pkg::S_READ;
            default: state_next = spfa_pkg::S_IDLE;
          endcase
        end
      end
      spfa_pkg::S_LOAD: state_next = spfa_pkg::S_IDLE;
      spfa_pkg::S_CLEAR: if (idx == NW'(spfa_pkg::MaxNodes - 1)) state_next = spfa_pkg::S_POP;
      spfa_pkg::S_POP: state_next = (ring_fill == '0) ? spfa_pkg::S_DONE : spfa_pkg::S_HEAD;
      spfa_pkg::S_HEAD: begin
        dist_ra = r_ring;
        head_ra = r_ring;
        state_next = spfa_pkg::S_FETCH;
      end
      spfa_pkg::S_FETCH: state_next = spfa_pkg::S_EDGE;
      spfa_pkg::S_EDGE: begin
        if (eptr == spfa_pkg::NullLink)
          state_next = (cur == '0 && top != '0) ? spfa_pkg::S_IDIST : spfa_pkg::S_POP;
        else
          state_next = spfa_pkg::S_DIST;
      end
      spfa_pkg::S_DIST: begin
        dist_ra = r_tgt;
        state_next = spfa_pkg::S_RELAX;
      end
      spfa_pkg::S_IDIST: begin
        dist_ra = idx;
        state_next = spfa_pkg::S_RELAX;
      end
      spfa_pkg::S_RELAX: begin
        edge_ra = r_lnk[EW-1:0];
        state_next = spfa_pkg::S_IMPL;
      end
      spfa_pkg::S_IMPL: begin
        // check count after each edge
        if (r_cnt > {1'b0, node_count} ||
            (rsp.improve && !r_inq && (r_cnt + 1'b1) > {1'b0, node_count}))
          state_next = spfa_pkg::S_DONE;
        else if (ew_impl)
          state_next = (idx == NW'(1)) ? spfa_pkg::S_POP : spfa_pkg::S_IDIST;
        else
          state_next = spfa_pkg::S_EDGE;
      end
      spfa_pkg::S_DONE: state_next = spfa_pkg::S_IDLE;
      spfa_pkg::S_READ: state_next = spfa_pkg::S_IDLE;
      default: state_next = spfa_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    r_dist <= dist_mem[dist_ra];
    r_cnt <= cnt[dist_ra];
    r_inq <= in_q[dist_ra];
    r_head <= head[head_ra];
    r_ring <= ring[ring_ra];
    r_tgt <= e_tgt[edge_ra];
    r_wt <= e_wt[edge_ra];
    r_lnk <= e_lnk[edge_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spfa_pkg::S_INIT;
      node_count <= NW'(1);
      edge_used <= '0;
      ovf <= 1'b0;
      done <= 1'b0;
      ring_fill <= '0;
      rd_start <= '0;
      cycle <= 1'b0;
      idx <= '0;
      ew_impl <= 1'b0;
    end else begin
      state <= state_next;
      done <= 1'b0;
      if (psel && penable && pwrite && paddr == 1'b0) node_count <= pwdata[NW-1:0];
      case (state)
        spfa_pkg::S_INIT: begin
          head[idx] <= spfa_pkg::NullLink;
          dist_mem[idx] <= spfa_pkg::Unreached;
          idx <= idx + 1'b1;
        end
        spfa_pkg::S_IDLE: begin
          if (accept && kind == spfa_pkg::KindLoad) begin
            if (edge_used[EW]) ovf <= 1'b1;
            else begin
              e_tgt[edge_used[EW-1:0]] <= to_node;
              e_wt[edge_used[EW-1:0]] <= weight;
              ld_from <= from_node;
            end
          end
          idx <= '0;
          cycle <= 1'b0;
        end
        // link the new edge in front of the old head read last cycle
        spfa_pkg::S_LOAD: begin
          e_lnk[edge_used[EW-1:0]] <= r_head;
          head[ld_from] <= edge_used;
          edge_used <= edge_used + 1'b1;
        end
        spfa_pkg::S_CLEAR: begin
          dist_mem[idx] <= (idx == '0) ? 32'd0 : spfa_pkg::Unreached;
          cnt[idx] <= (idx == '0) ? spfa_pkg::CountW'(1) : '0;
          in_q[idx] <= (idx == '0);
          idx <= idx + 1'b1;
          if (idx == '0) begin
            ring[0] <= '0;
            rd_start <= '0;
            ring_fill <= (NW+1)'(1);
          end
        end
        spfa_pkg::S_POP: ;
        spfa_pkg::S_HEAD: begin
          cur <= r_ring;
          in_q[r_ring] <= 1'b0;
          rd_start <= rd_start + 1'b1;
          ring_fill <= ring_fill - 1'b1;
          idx <= top;
          ew_impl <= 1'b0;
        end
        spfa_pkg::S_FETCH: begin
          eptr <= r_head;
          cur_dist <= r_dist;
        end
        spfa_pkg::S_EDGE: begin
          if (eptr == spfa_pkg::NullLink) ew_impl <= 1'b1;
        end
        spfa_pkg::S_DIST: begin
          dst <= r_tgt;
          ew <= r_wt;
        end
        spfa_pkg::S_IDIST: begin
          dst <= idx;
          ew <= '0;
        end
        spfa_pkg::S_RELAX: begin
          if (!ew_impl) eptr <= r_lnk;
        end
        spfa_pkg::S_IMPL: begin
          if (rsp.improve) begin
            dist_mem[dst] <= rsp.sum;
            // a self loop lowers the source for the rest of the scan
            if (dst == cur) cur_dist <= rsp.sum;
            if (!r_inq) begin
              in_q[dst] <= 1'b1;
              cnt[dst] <= r_cnt + 1'b1;
              if (!ring_fill[NW]) begin
                ring[ring_fill_lo] <= dst;
                ring_fill <= ring_fill + 1'b1;
              end
            end
          end
          if (ew_impl) idx <= idx - 1'b1;
          if (state_next == spfa_pkg::S_DONE) cycle <= 1'b1;
        end
        spfa_pkg::S_DONE: begin
          done <= 1'b1;
          is_distance <= 1'b0;
          distance <= '0;
          status <= ovf ? spfa_pkg::StatOvf : (cycle ? spfa_pkg::StatCycle : spfa_pkg::StatOk);
        end
        spfa_pkg::S_READ: begin
          done <= 1'b1;
          is_distance <= 1'b1;
          status <= spfa_pkg::StatOk;
          distance <= r_dist;
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_busy_done: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy)) else $error("result without command");
  a_fill: assert property (@(posedge clk) disable iff (rst)
    ring_fill <= (NW+1)'(spfa_pkg::MaxNodes)) else $error("ring overfull");
  a_one_done: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("double result");
`endif
endmodule
`default_nettype wire
